// ===== hdl/tcgr_pkg.sv =====
// Shared types, codes and font geometry of the text console glyph renderer.
package tcgr_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FONT_SET = 2'd0;
  localparam logic [1:0] CFG_COLUMNS  = 2'd1;
  localparam logic [1:0] CFG_ROWS     = 2'd2;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7F;

  // Width of the glyph line counters; the tallest cell has twelve lines.
  localparam int unsigned LINE_W = 4;

  typedef enum logic [1:0] {
    KIND_ROW    = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_GLYPH,
    ST_FLUSH,
    ST_SCROLL,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic  item_latch;
    logic  mem_wr;
    logic  glyph_start;
    logic  rd_issue;
    logic  out_load;
    kind_e out_kind;
    logic  out_last;
    logic  cursor_commit;
    logic  cursor_home;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_clear;
    logic is_put;
    logic is_newline;
    logic is_print;
    logic need_scroll;
    logic issue_done;
    logic read_last;
  } dp_status_t;

  // Cell width in pixels: font 0 is a 9 wide cell, font 1 a 6 wide cell.
  function automatic logic [3:0] cell_width(input logic font_idx);
    return font_idx ? 4'd6 : 4'd9;
  endfunction

  // Cell height in pixel lines.
  function automatic logic [LINE_W-1:0] cell_height(input logic font_idx);
    return font_idx ? LINE_W'(12) : LINE_W'(8);
  endfunction

endpackage

// ===== hdl/tcgr_ctrl.sv =====
// Controller state machine of the text console glyph renderer.
module tcgr_ctrl
  import tcgr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   rd_valid_q, rd_valid_d;
  logic   out_free;
  logic   consume;

  // The output register can take a new request when empty or being emptied.
  assign out_free = !out_valid_q || out_ready_i;
  assign consume  = (state_q == ST_GLYPH) && rd_valid_q && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (status_i.is_clear) begin
          state_d = ST_CLEAR;
        end else if (status_i.is_put && status_i.is_print) begin
          state_d = ST_GLYPH;
        end else if (status_i.is_put && status_i.is_newline) begin
          state_d = ST_FLUSH;
        end else if (status_i.is_put && status_i.need_scroll) begin
          state_d = ST_SCROLL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_GLYPH: begin
        if (consume && status_i.read_last) begin
          state_d = status_i.need_scroll ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) state_d = status_i.need_scroll ? ST_SCROLL : ST_IDLE;
      end
      ST_SCROLL: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.item_latch = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.mem_wr      = status_i.is_load;
        cmd_o.glyph_start = status_i.is_put && status_i.is_print;
        cmd_o.cursor_commit = status_i.is_put && !status_i.is_print &&
                              !status_i.is_newline && !status_i.need_scroll;
      end
      ST_GLYPH: begin
        cmd_o.rd_issue = !status_i.issue_done && (!rd_valid_q || out_free);
        cmd_o.out_load = consume;
        cmd_o.out_kind = KIND_ROW;
        cmd_o.out_last = status_i.read_last && !status_i.need_scroll;
        cmd_o.cursor_commit = consume && status_i.read_last && !status_i.need_scroll;
      end
      ST_FLUSH: begin
        cmd_o.out_load      = out_free;
        cmd_o.out_kind      = KIND_FLUSH;
        cmd_o.out_last      = !status_i.need_scroll;
        cmd_o.cursor_commit = out_free && !status_i.need_scroll;
      end
      ST_SCROLL: begin
        cmd_o.out_load      = out_free;
        cmd_o.out_kind      = KIND_SCROLL;
        cmd_o.out_last      = 1'b1;
        cmd_o.cursor_commit = out_free;
      end
      ST_CLEAR: begin
        cmd_o.out_load    = out_free;
        cmd_o.out_kind    = KIND_CLEAR;
        cmd_o.out_last    = 1'b1;
        cmd_o.cursor_home = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    rd_valid_d = rd_valid_q;
    if (cmd_o.glyph_start) begin
      rd_valid_d = 1'b0;
    end else if (cmd_o.rd_issue) begin
      rd_valid_d = 1'b1;
    end else if (consume) begin
      rd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= rd_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A waiting request is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while stalled");

  // An accepted request is always decoded next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted request not decoded");

  // Glyph reads are only in flight while a glyph is being drawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q == ST_GLYPH))
    else $error("glyph read pending outside glyph drawing");

  // No read is issued once all rows of the glyph have been issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |-> (state_q == ST_GLYPH && !status_i.issue_done))
    else $error("glyph read issued past the last row");

endmodule

// ===== hdl/tcgr_dp.sv =====
// Datapath of the text console glyph renderer: registers, cursor, glyph store, output.
module tcgr_dp
  import tcgr_pkg::*;
#(
  parameter int unsigned FONT_COUNT     = 2,
  parameter int unsigned GLYPH_COUNT    = 96,
  parameter int unsigned GLYPH_ROWS_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  char_code_i,
  input  logic        load_font_i,
  input  logic [6:0]  load_glyph_i,
  input  logic [3:0]  load_row_i,
  input  logic [7:0]  load_byte_i,
  input  logic [31:0] fill_color_i,
  input  ctrl_cmd_t   cmd_in_i,
  output dp_status_t  status_o,
  output logic [1:0]  kind_o,
  output logic [13:0] pixel_x_o,
  output logic [12:0] pixel_y_o,
  output logic [8:0]  row_bits_o,
  output logic [3:0]  row_width_o,
  output logic [4:0]  scroll_lines_o,
  output logic [31:0] clear_color_o,
  output logic        last_o
);

  localparam int unsigned Depth  = FONT_COUNT * GLYPH_COUNT * GLYPH_ROWS_MAX;
  localparam int unsigned ADDR_W = $clog2(Depth);

  // Configuration and cursor.
  logic       font_set_q;
  logic [9:0] columns_q;
  logic [8:0] rows_q;
  logic [9:0] col_q;
  logic [8:0] row_q;

  // Latched request.
  logic [1:0]  item_cmd_q;
  logic [7:0]  item_char_q;
  logic        item_font_q;
  logic [6:0]  item_glyph_q;
  logic [3:0]  item_row_q;
  logic [7:0]  item_byte_q;
  logic [31:0] item_fill_q;

  // Glyph line counters and read data.
  logic [LINE_W-1:0] line_iss_q, line_rd_q;
  logic [7:0]        rd_data_q;
  logic [7:0]        glyph_mem [Depth];

  logic              font_sel;
  logic [3:0]        cw;
  logic [LINE_W-1:0] ch;
  logic              is_print, is_nl, is_cr, load_ok;
  logic [10:0]       col_p;
  logic [9:0]        row_p, row_w;
  logic [9:0]        col_n;
  logic [8:0]        row_n;
  logic              wrap, scroll;
  logic [6:0]        glyph_idx;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  logic [1:0]  kind_d;
  logic [13:0] x_d;
  logic [12:0] y_d;
  logic [8:0]  bits_d;
  logic [3:0]  width_d;
  logic [4:0]  lines_d;
  logic [31:0] color_d;

  assign font_sel = (FONT_COUNT > 1) ? font_set_q : 1'b0;
  assign cw       = cell_width(font_sel);
  assign ch       = cell_height(font_sel);

  assign is_nl    = item_char_q == CHAR_NEWLINE;
  assign is_cr    = item_char_q == CHAR_RETURN;
  assign is_print = (item_char_q >= CHAR_FIRST) && (item_char_q <= CHAR_LAST);
  assign load_ok  = (32'(item_font_q) < FONT_COUNT) && (32'(item_glyph_q) < GLYPH_COUNT) &&
                    (32'(item_row_q) < GLYPH_ROWS_MAX);

  // Cursor after this character: advance, wrap at the last column, clamp at the last row.
  always_comb begin
    if (is_print) begin
      col_p = {1'b0, col_q} + 11'd1;
    end else if (is_nl || is_cr) begin
      col_p = '0;
    end else begin
      col_p = {1'b0, col_q};
    end
    row_p  = is_nl ? ({1'b0, row_q} + 10'd1) : {1'b0, row_q};
    wrap   = col_p >= {1'b0, columns_q};
    col_n  = wrap ? '0 : col_p[9:0];
    row_w  = wrap ? (row_p + 10'd1) : row_p;
    scroll = row_w >= {1'b0, rows_q};
    row_n  = scroll ? (rows_q - 9'd1) : row_w[8:0];
  end

  assign glyph_idx = 7'(item_char_q - CHAR_FIRST);
  assign rd_addr = ADDR_W'((32'(font_sel) * GLYPH_COUNT + 32'(glyph_idx)) * GLYPH_ROWS_MAX +
                           32'(line_iss_q));
  assign wr_addr = ADDR_W'((32'(item_font_q) * GLYPH_COUNT + 32'(item_glyph_q)) *
                           GLYPH_ROWS_MAX + 32'(item_row_q));

  always_comb begin
    status_o             = '0;
    status_o.is_load     = item_cmd_q == CMD_LOAD;
    status_o.is_clear    = item_cmd_q == CMD_CLEAR;
    status_o.is_put      = (item_cmd_q == CMD_PUT) && (columns_q != '0) && (rows_q != '0);
    status_o.is_newline  = is_nl;
    status_o.is_print    = is_print;
    status_o.need_scroll = scroll;
    status_o.issue_done  = line_iss_q == ch;
    status_o.read_last   = line_rd_q == (ch - LINE_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_set_q <= 1'b0;
      columns_q  <= '0;
      rows_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      line_iss_q <= '0;
      line_rd_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FONT_SET: font_set_q <= cfg_data_i[0];
          CFG_COLUMNS:  columns_q  <= cfg_data_i;
          CFG_ROWS:     rows_q     <= cfg_data_i[8:0];
          default:      ;
        endcase
      end
      if (cmd_in_i.cursor_home) begin
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_in_i.cursor_commit) begin
        col_q <= col_n;
        row_q <= row_n;
      end
      if (cmd_in_i.glyph_start) begin
        line_iss_q <= '0;
      end else if (cmd_in_i.rd_issue) begin
        line_iss_q <= line_iss_q + LINE_W'(1);
        line_rd_q  <= line_iss_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.item_latch) begin
      item_cmd_q   <= cmd_i;
      item_char_q  <= char_code_i;
      item_font_q  <= load_font_i;
      item_glyph_q <= load_glyph_i;
      item_row_q   <= load_row_i;
      item_byte_q  <= load_byte_i;
      item_fill_q  <= fill_color_i;
    end
  end

  // Glyph store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.mem_wr && load_ok) begin
      glyph_mem[wr_addr] <= item_byte_q;
    end
    if (cmd_in_i.rd_issue) begin
      rd_data_q <= glyph_mem[rd_addr];
    end
  end

  always_comb begin
    kind_d  = cmd_in_i.out_kind;
    x_d     = '0;
    y_d     = '0;
    bits_d  = '0;
    width_d = '0;
    lines_d = '0;
    color_d = '0;
    case (cmd_in_i.out_kind)
      KIND_ROW: begin
        x_d     = 14'(col_q) * 14'(cw);
        y_d     = 13'(row_q) * 13'(ch) + 13'(line_rd_q);
        bits_d  = font_sel ? {3'b000, rd_data_q[7:2]} : {rd_data_q, 1'b0};
        width_d = cw;
      end
      KIND_SCROLL: lines_d = 5'(ch);
      KIND_CLEAR:  color_d = item_fill_q;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.out_load) begin
      kind_o         <= kind_d;
      pixel_x_o      <= x_d;
      pixel_y_o      <= y_d;
      row_bits_o     <= bits_d;
      row_width_o    <= width_d;
      scroll_lines_o <= lines_d;
      clear_color_o  <= color_d;
      last_o         <= cmd_in_i.out_last;
    end
  end

endmodule

// ===== hdl/text_console_glyph_renderer_top.sv =====
// Top level of the text console glyph renderer.
//
// The renderer takes one request at a time and turns it into framebuffer
// commands. A put character request with a printable code draws one pixel
// row write per glyph line (eight for the 9x8 cell, twelve for the 6x12
// cell), then advances the cursor, wrapping at the last column and asking
// for a scroll by one text line when it runs past the last row. Newline
// sends a flush, carriage return homes the column, and a clear request sends
// a single fill and homes the cursor. A load request writes one byte of the
// glyph store and produces nothing; a glyph must be loaded before it is drawn,
// since the store comes up with unknown contents. The last flag marks the
// final command caused by a request. The glyph store's single read port
// delivers one glyph line per cycle while the output is not stalled,
// which sets the drawing rate. The output sits in a register, so the
// next request is taken while the last command still waits. Configuration
// must be written only while the renderer is idle; the block itself does
// not enforce this. Register 0 selects the font, 1 the number of text
// columns, 2 the number of text rows, and with zero columns or rows
// characters are ignored.
module text_console_glyph_renderer_top
  import tcgr_pkg::*;
#(
  parameter int unsigned FONT_COUNT     = 2,
  parameter int unsigned GLYPH_COUNT    = 96,
  parameter int unsigned GLYPH_ROWS_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  char_code_i,
  input  logic        load_font_i,
  input  logic [6:0]  load_glyph_i,
  input  logic [3:0]  load_row_i,
  input  logic [7:0]  load_byte_i,
  input  logic [31:0] fill_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [13:0] pixel_x_o,
  output logic [12:0] pixel_y_o,
  output logic [8:0]  row_bits_o,
  output logic [3:0]  row_width_o,
  output logic [4:0]  scroll_lines_o,
  output logic [31:0] clear_color_o,
  output logic        last_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // The controller sequences each request; the datapath holds all data.
  tcgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  tcgr_dp #(
    .FONT_COUNT     (FONT_COUNT),
    .GLYPH_COUNT    (GLYPH_COUNT),
    .GLYPH_ROWS_MAX (GLYPH_ROWS_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .char_code_i    (char_code_i),
    .load_font_i    (load_font_i),
    .load_glyph_i   (load_glyph_i),
    .load_row_i     (load_row_i),
    .load_byte_i    (load_byte_i),
    .fill_color_i   (fill_color_i),
    .cmd_in_i       (ctrl_cmd),
    .status_o       (dp_status),
    .kind_o         (kind_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .row_bits_o     (row_bits_o),
    .row_width_o    (row_width_o),
    .scroll_lines_o (scroll_lines_o),
    .clear_color_o  (clear_color_o),
    .last_o         (last_o)
  );

endmodule
